@@ rtl/sebd_pkg.sv @@
package sebd_pkg;

  localparam int BAND_W = 9;

  typedef struct packed {
    logic signed [23:0] bin_real;
    logic signed [23:0] bin_imag;
    logic               last_bin;
  } in_item_t;

  typedef struct packed {
    logic       is_pulse;
    logic [6:0] trigger_band;
  } out_item_t;

  typedef struct packed {
    logic              wr;
    logic              fin;
    logic [BAND_W-1:0] band;
    logic [31:0]       data;
  } qent_t;

  typedef struct packed {
    logic [11:0] mean_threshold;
    logic [31:0] deviation_threshold;
    logic [6:0]  history_depth;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_MEAN_THR  = 2'd0,
    CFG_DEV_THR   = 2'd1,
    CFG_DEPTH     = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ZFILL, ST_CNT, ST_NN, ST_DT, ST_XRD, ST_SUM, ST_SWAIT,
    ST_DEV, ST_DWAIT1, ST_DWAIT2, ST_CMP, ST_OUT
  } bst_t;

  typedef enum logic [1:0] {
    TAG_NONE, TAG_X, TAG_SUM, TAG_DEV
  } rtag_t;

  function automatic int n_groups(int fft);
    int start;
    int size;
    int n;
    start = 0;
    size = 8;
    n = 0;
    while (start + size <= fft / 4) begin
      n++;
      start += size;
      size = size * 2;
    end
    return n;
  endfunction

  function automatic int n_bands(int fft);
    int n;
    n = fft / 16 + n_groups(fft);
    return (n < fft / 16 + 32) ? n : fft / 16 + 32;
  endfunction

endpackage

@@ rtl/subband_energy_beat_detector.sv @@
// Bins are taken at one item per cycle while the queue to the statistics engine has room.
// After a frame-end item leaves the queue, the engine zeroes the bands a short frame left
// open, then for each band reads the filled history rows once for the sum and once for the
// deviation through the single history memory read port, stopping at the first pulse band.
// The next frame's bins are taken meanwhile until the four-entry queue fills.
// Reset is synchronous and active low; it clears control state and loads register defaults.
module subband_energy_beat_detector #(
  parameter int FFT_SIZE    = 1024,
  parameter int HISTORY_MAX = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  sebd_pkg::in_item_t  in_item,
  input  logic                out_pop,
  output logic                out_empty,
  output sebd_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  sebd_pkg::cfg_t  cfg_r;
  sebd_pkg::qent_t f_ent, b_ent;
  logic            f_push, q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mean_threshold      <= 12'd333;
      cfg_r.deviation_threshold <= 32'd0;
      cfg_r.history_depth       <= 7'd43;
    end else if (cfg_valid) begin
      unique case (sebd_pkg::cfg_idx_t'(cfg_index))
        sebd_pkg::CFG_MEAN_THR: cfg_r.mean_threshold      <= cfg_data[11:0];
        sebd_pkg::CFG_DEV_THR:  cfg_r.deviation_threshold <= cfg_data;
        sebd_pkg::CFG_DEPTH:    cfg_r.history_depth       <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  sebd_front #(.FFT_SIZE(FFT_SIZE)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (f_push),
    .q_ent   (f_ent)
  );

  sebd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_ent),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (b_ent)
  );

  sebd_back #(.FFT_SIZE(FFT_SIZE), .HISTORY_MAX(HISTORY_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_ent     (b_ent),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

@@ rtl/sebd_front.sv @@
module sebd_front #(
  parameter int FFT_SIZE = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  sebd_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_push,
  output sebd_pkg::qent_t    q_ent
);

  localparam int PW  = $clog2(FFT_SIZE + 1);
  localparam int Q   = FFT_SIZE / 4;
  localparam int H   = FFT_SIZE / 2;
  localparam int NB1 = Q / 4;
  localparam int NG  = sebd_pkg::n_groups(FFT_SIZE);
  localparam int NBT = sebd_pkg::n_bands(FFT_SIZE);
  localparam int END2 = (8 << NG) - 8;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          acc_ok;
  logic          use_bin;
  logic          closes;
  logic [PW-1:0] off;
  logic [sebd_pkg::BAND_W-1:0] band;
  logic [sebd_pkg::BAND_W-1:0] kcnt;
  logic [24:0]   ar, ai;
  logic [32:0]   sum;
  logic [31:0]   sat;

  function automatic logic [24:0] abs24(input logic [23:0] x);
    return x[23] ? (25'h1000000 - {1'b0, x}) : {1'b0, x};
  endfunction

  always_comb begin
    off = pos_r - PW'(Q);
    kcnt = '0;
    closes = 1'b0;
    use_bin = 1'b0;
    band = '0;
    if (pos_r < PW'(Q)) begin
      use_bin = 1'b1;
      band = sebd_pkg::BAND_W'(pos_r >> 2);
      closes = (pos_r[1:0] == 2'b11);
    end else if (pos_r < PW'(H) && off < PW'(END2)) begin
      use_bin = 1'b1;
      for (int i = 0; i < NG; i++) begin
        if (off >= PW'((8 << (i + 1)) - 8)) begin
          kcnt = kcnt + 1'b1;
        end
        if (off + 1'b1 == PW'((8 << (i + 1)) - 8)) begin
          closes = 1'b1;
        end
      end
      band = sebd_pkg::BAND_W'(NB1) + kcnt;
    end
    acc_ok = use_bin && (band < sebd_pkg::BAND_W'(NBT));
  end

  assign ar  = abs24(in_item.bin_real);
  assign ai  = abs24(in_item.bin_imag);
  assign sum = {1'b0, acc_r} + 33'(ar) + 33'(ai);
  assign sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign in_full = q_full;

  always_comb begin
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    q_push  = 1'b0;
    q_ent.wr   = acc_ok && closes;
    q_ent.fin  = in_item.last_bin;
    q_ent.band = band;
    q_ent.data = sat;
    if (in_push && !q_full) begin
      if (acc_ok) begin
        acc_nxt = closes ? 32'd0 : sat;
      end
      if (pos_r < PW'(FFT_SIZE)) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (in_item.last_bin) begin
        pos_nxt = '0;
        acc_nxt = '0;
      end
      q_push = (acc_ok && closes) || in_item.last_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

@@ rtl/sebd_fifo.sv @@
module sebd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sebd_pkg::qent_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output sebd_pkg::qent_t rdata
);

  sebd_pkg::qent_t ent_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign rdata   = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule

@@ rtl/sebd_back.sv @@
module sebd_back #(
  parameter int FFT_SIZE    = 1024,
  parameter int HISTORY_MAX = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sebd_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  sebd_pkg::qent_t     q_ent,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output sebd_pkg::out_item_t out_item
);

  localparam int NB  = sebd_pkg::n_bands(FFT_SIZE);
  localparam int BW  = $clog2(NB);
  localparam int NW  = $clog2(HISTORY_MAX + 1);
  localparam int RW  = $clog2(HISTORY_MAX);
  localparam int AW  = RW + BW;
  localparam int SW  = 32 + NW;
  localparam int DW  = 32 + 2 * NW;
  localparam int CW  = SW + 12;
  localparam int HXW = (NW > 7) ? NW : 7;
  localparam int ZW  = sebd_pkg::BAND_W;

  logic [31:0] mem [2**AW];

  sebd_pkg::bst_t  st_r, st_nxt;
  sebd_pkg::rtag_t rtag_r, rtag_nxt;
  logic [RW-1:0] slot_r, slot_nxt, slot_use;
  logic [NW-1:0] filled_r, filled_nxt;
  logic [ZW-1:0] fillp_r, fillp_nxt;
  logic [ZW-1:0] zb_r, zb_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [NW-1:0] j_r, j_nxt;
  logic          pvld_r;
  logic          ovld_r, ovld_nxt;
  sebd_pkg::out_item_t oitem_r, oitem_nxt;
  sebd_pkg::out_item_t pend_r, pend_nxt;

  logic          we, re, s_clr, dev_clr;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wd;
  logic [31:0]   rdata_r;

  logic [NW-1:0]   d;
  logic [HXW-1:0]  dep_x;
  logic [NW-1:0]   slot_inc, fcl;
  logic [31:0]     x_r;
  logic [SW-1:0]   s_r, prod_r, adiff;
  logic [DW-1:0]   dev_r, dtn_r;
  logic [2*NW-1:0] nn_r;
  logic [SW-1:0]   xn_r;
  logic [CW-1:0]   smt_r;
  logic            pass;

  always_comb begin
    dep_x = HXW'(cfg.history_depth);
    if (dep_x == '0) begin
      d = NW'(1);
    end else if (dep_x > HXW'(HISTORY_MAX)) begin
      d = NW'(HISTORY_MAX);
    end else begin
      d = NW'(dep_x);
    end
    slot_use = (NW'(slot_r) >= d) ? '0 : slot_r;
    slot_inc = NW'(slot_use) + 1'b1;
    fcl      = (filled_r > d) ? d : filled_r;
    adiff    = (prod_r > s_r) ? (prod_r - s_r) : (s_r - prod_r);
    pass     = (CW'({xn_r, 8'h00}) > smt_r) && (dev_r > dtn_r);
  end

  always_comb begin
    st_nxt     = st_r;
    rtag_nxt   = sebd_pkg::TAG_NONE;
    slot_nxt   = slot_r;
    filled_nxt = filled_r;
    fillp_nxt  = fillp_r;
    zb_nxt     = zb_r;
    b_nxt      = b_r;
    j_nxt      = j_r;
    ovld_nxt   = ovld_r && !out_pop;
    oitem_nxt  = oitem_r;
    pend_nxt   = pend_r;
    q_pop      = 1'b0;
    we         = 1'b0;
    wa         = {slot_use, zb_r[BW-1:0]};
    wd         = 32'd0;
    re         = 1'b0;
    ra         = {slot_use, b_r};
    s_clr      = 1'b0;
    dev_clr    = 1'b0;
    unique case (st_r)
      sebd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_ent.wr) begin
            we        = 1'b1;
            wa        = {slot_use, q_ent.band[BW-1:0]};
            wd        = q_ent.data;
            fillp_nxt = q_ent.band + 1'b1;
          end
          if (q_ent.fin) begin
            zb_nxt = q_ent.wr ? (q_ent.band + 1'b1) : fillp_r;
            st_nxt = sebd_pkg::ST_ZFILL;
          end
        end
      end
      sebd_pkg::ST_ZFILL: begin
        if (zb_r < ZW'(NB)) begin
          we     = 1'b1;
          zb_nxt = zb_r + 1'b1;
        end else begin
          st_nxt = sebd_pkg::ST_CNT;
        end
      end
      sebd_pkg::ST_CNT: begin
        filled_nxt = (fcl < d) ? fcl + 1'b1 : fcl;
        fillp_nxt  = '0;
        st_nxt     = sebd_pkg::ST_NN;
      end
      sebd_pkg::ST_NN: begin
        st_nxt = sebd_pkg::ST_DT;
      end
      sebd_pkg::ST_DT: begin
        b_nxt  = '0;
        st_nxt = sebd_pkg::ST_XRD;
      end
      sebd_pkg::ST_XRD: begin
        re       = 1'b1;
        rtag_nxt = sebd_pkg::TAG_X;
        s_clr    = 1'b1;
        j_nxt    = '0;
        st_nxt   = sebd_pkg::ST_SUM;
      end
      sebd_pkg::ST_SUM: begin
        re       = 1'b1;
        ra       = {j_r[RW-1:0], b_r};
        rtag_nxt = sebd_pkg::TAG_SUM;
        j_nxt    = j_r + 1'b1;
        if (j_r + 1'b1 >= filled_r) begin
          st_nxt = sebd_pkg::ST_SWAIT;
        end
      end
      sebd_pkg::ST_SWAIT: begin
        dev_clr = 1'b1;
        j_nxt   = '0;
        st_nxt  = sebd_pkg::ST_DEV;
      end
      sebd_pkg::ST_DEV: begin
        re       = 1'b1;
        ra       = {j_r[RW-1:0], b_r};
        rtag_nxt = sebd_pkg::TAG_DEV;
        j_nxt    = j_r + 1'b1;
        if (j_r + 1'b1 >= filled_r) begin
          st_nxt = sebd_pkg::ST_DWAIT1;
        end
      end
      sebd_pkg::ST_DWAIT1: begin
        st_nxt = sebd_pkg::ST_DWAIT2;
      end
      sebd_pkg::ST_DWAIT2: begin
        st_nxt = sebd_pkg::ST_CMP;
      end
      sebd_pkg::ST_CMP: begin
        if (pass) begin
          pend_nxt.is_pulse     = 1'b1;
          pend_nxt.trigger_band = 7'(b_r);
          st_nxt                = sebd_pkg::ST_OUT;
        end else if (b_r == BW'(NB - 1)) begin
          pend_nxt.is_pulse     = 1'b0;
          pend_nxt.trigger_band = '0;
          st_nxt                = sebd_pkg::ST_OUT;
        end else begin
          b_nxt  = b_r + 1'b1;
          st_nxt = sebd_pkg::ST_XRD;
        end
      end
      sebd_pkg::ST_OUT: begin
        if (!ovld_r || out_pop) begin
          ovld_nxt  = 1'b1;
          oitem_nxt = pend_r;
          slot_nxt  = (slot_inc >= d) ? '0 : RW'(slot_inc);
          st_nxt    = sebd_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = sebd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rtag_r == sebd_pkg::TAG_X) begin
      x_r <= rdata_r;
    end
    if (s_clr) begin
      s_r <= '0;
    end else if (rtag_r == sebd_pkg::TAG_SUM) begin
      s_r <= s_r + SW'(rdata_r);
    end
    if (dev_clr) begin
      dev_r <= '0;
    end else if (pvld_r) begin
      dev_r <= dev_r + DW'(adiff);
    end
    prod_r  <= SW'(rdata_r) * SW'(filled_r);
    xn_r    <= SW'(x_r) * SW'(filled_r);
    smt_r   <= CW'(s_r) * CW'(cfg.mean_threshold);
    nn_r    <= (2*NW)'(filled_r) * (2*NW)'(filled_r);
    dtn_r   <= DW'(cfg.deviation_threshold) * DW'(nn_r);
    oitem_r <= oitem_nxt;
    pend_r  <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= sebd_pkg::ST_IDLE;
      rtag_r   <= sebd_pkg::TAG_NONE;
      slot_r   <= '0;
      filled_r <= '0;
      fillp_r  <= '0;
      zb_r     <= '0;
      b_r      <= '0;
      j_r      <= '0;
      pvld_r   <= 1'b0;
      ovld_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      rtag_r   <= rtag_nxt;
      slot_r   <= slot_nxt;
      filled_r <= filled_nxt;
      fillp_r  <= fillp_nxt;
      zb_r     <= zb_nxt;
      b_r      <= b_nxt;
      j_r      <= j_nxt;
      pvld_r   <= (rtag_r == sebd_pkg::TAG_DEV);
      ovld_r   <= ovld_nxt;
    end
  end

  assign out_empty = !ovld_r;
  assign out_item  = oitem_r;

endmodule

@@ rtl/sebd_check.sv @@
module sebd_check (
  input logic                clk,
  input logic                rst_n,
  input logic                out_pop,
  input logic                out_empty,
  input sebd_pkg::out_item_t out_item,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("Result queue is not empty after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("Waiting item changed before it was taken.");

  a_no_pulse_band: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_item.is_pulse |-> out_item.trigger_band == 7'd0)
    else $error("Trigger band is set on an item without a pulse.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("Configuration write was refused.");

endmodule

bind subband_energy_beat_detector sebd_check u_sebd_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_item  (out_item),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int FFT_LEN = 1024;
  localparam int ROWS_MAX = 64;
  localparam int BANDS = 69;
  localparam int SLOTS = FFT_LEN / 16 + 32;
  localparam int DRAIN_WAIT = 12000;
  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  sebd_pkg::in_item_t in_item = '0;
  logic out_pop = 1'b0;
  logic out_empty;
  sebd_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  subband_energy_beat_detector u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_pop(out_pop), .out_empty(out_empty), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  logic [11:0] mean_thr;
  logic [31:0] dev_thr;
  logic [6:0] depth_reg;
  logic [31:0] history [ROWS_MAX][SLOTS];
  bit row_written [ROWS_MAX];
  logic [31:0] band_sum;
  int bin_pos;
  int ring_slot;
  int rows_filled;

  sebd_pkg::out_item_t pulse_due [$];
  int mismatches = 0;
  int bins_sent = 0;
  bit quiet = 1'b0;
  int pop_hold = 0;
  int idle_cycles = 0;

  function automatic int eff_depth(logic [6:0] v);
    if (v == 0) return 1;
    return (v > ROWS_MAX) ? ROWS_MAX : int'(v);
  endfunction

  function automatic logic [24:0] mag24(logic signed [23:0] v);
    return v[23] ? 25'(-$signed({v[23], v})) : {1'b0, v};
  endfunction

  task automatic predict_bin(sebd_pkg::in_item_t it);
    int d, band, o, st, sz, k, b, j;
    bit hit, closes;
    logic [63:0] s, n, tot, dev, t, x;
    sebd_pkg::out_item_t r;
    d = eff_depth(depth_reg);
    if (ring_slot >= d) ring_slot = 0;
    if (bin_pos == 0) begin
      for (b = 0; b < SLOTS; b++) history[ring_slot][b] = '0;
      row_written[ring_slot] = 1'b1;
    end
    hit = 1'b0;
    if (bin_pos < FFT_LEN / 4) begin
      band = bin_pos / 4;
      closes = (bin_pos % 4) == 3;
      hit = 1'b1;
    end else if (bin_pos < FFT_LEN / 2) begin
      o = bin_pos - FFT_LEN / 4;
      st = 0;
      sz = 8;
      k = 0;
      while (o >= st + sz) begin
        st += sz;
        sz *= 2;
        k++;
      end
      hit = (st + sz) <= FFT_LEN / 4;
      band = FFT_LEN / 16 + k;
      closes = o == st + sz - 1;
    end
    if (hit && band < SLOTS) begin
      s = 64'(band_sum) + 64'(mag24(it.bin_real)) + 64'(mag24(it.bin_imag));
      band_sum = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      if (closes) begin
        history[ring_slot][band] = band_sum;
        band_sum = '0;
      end
    end
    if (bin_pos < FFT_LEN) bin_pos++;
    if (!it.last_bin) return;
    if (rows_filled > d) rows_filled = d;
    if (rows_filled < d) rows_filled++;
    r = '0;
    n = 64'(rows_filled);
    for (b = 0; b < BANDS; b++) begin
      tot = '0;
      dev = '0;
      for (j = 0; j < rows_filled; j++) tot += 64'(history[j][b]);
      for (j = 0; j < rows_filled; j++) begin
        t = n * 64'(history[j][b]);
        dev += (t > tot) ? t - tot : tot - t;
      end
      x = 64'(history[ring_slot][b]);
      if (x * n * 64'd256 > tot * 64'(mean_thr) && dev > 64'(dev_thr) * n * n) begin
        r.is_pulse = 1'b1;
        r.trigger_band = 7'(b);
        break;
      end
    end
    ring_slot++;
    if (ring_slot >= d) ring_slot = 0;
    bin_pos = 0;
    band_sum = '0;
    pulse_due = {pulse_due, r};
  endtask

  // A new depth is only allowed when no row that was never written can be read.
  function automatic bit depth_safe(logic [6:0] v);
    int e;
    bit all_rows;
    e = eff_depth(v);
    all_rows = 1'b1;
    for (int r = 0; r < e; r++) if (!row_written[r]) all_rows = 1'b0;
    return all_rows || (ring_slot == rows_filled && ring_slot < e);
  endfunction

  task automatic send_bin(logic signed [23:0] re, logic signed [23:0] im, logic last);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{bin_real: re, bin_imag: im, last_bin: last};
    do @(posedge clk); while (in_full);
    predict_bin(in_item);
    bins_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    wait (pulse_due.size() == 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(sebd_pkg::cfg_idx_t idx, logic [31:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sebd_pkg::CFG_MEAN_THR: mean_thr = val[11:0];
      sebd_pkg::CFG_DEV_THR: dev_thr = val;
      sebd_pkg::CFG_DEPTH: depth_reg = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_bin(int bits);
    logic [23:0] v;
    v = 24'($urandom);
    if (bits < 24) v = v & ((24'd1 << bits) - 24'd1);
    if ($urandom_range(0, 1)) v = -$signed(v);
    return v;
  endfunction

  task automatic send_frame(int len, int bits);
    for (int i = 0; i < len; i++) send_bin(rand_bin(bits), rand_bin(bits), i == len - 1);
  endtask

  task automatic test_directed();
    send_bin(-24'sd8388608, 24'sd8388607, 1'b1);
    send_bin(24'sd8388607, -24'sd8388608, 1'b0);
    send_bin(-24'sd1, 24'sd0, 1'b0);
    send_bin(24'sd0, 24'sd0, 1'b0);
    send_bin(-24'sd8388608, -24'sd8388608, 1'b1);
    send_bin(24'sd0, 24'sd0, 1'b1);
    send_frame(5, 24);
    send_frame(3, 4);
    write_reg(sebd_pkg::CFG_UNUSED, 32'hFFFF_FFFF);
    send_bin(24'sd100, 24'sd100, 1'b1);
  endtask

  task automatic test_registers();
    write_reg(sebd_pkg::CFG_DEPTH, 32'd0);
    send_frame(4, 24);
    send_frame(8, 20);
    write_reg(sebd_pkg::CFG_MEAN_THR, 32'd0);
    write_reg(sebd_pkg::CFG_DEPTH, 32'd2);
    send_frame(4, 24);
    send_frame(4, 10);
    write_reg(sebd_pkg::CFG_DEV_THR, 32'hFFFF_FFFF);
    send_frame(4, 24);
    write_reg(sebd_pkg::CFG_MEAN_THR, 32'hFFF);
    write_reg(sebd_pkg::CFG_DEV_THR, 32'd0);
    send_frame(4, 24);
    write_reg(sebd_pkg::CFG_MEAN_THR, 32'd333);
  endtask

  task automatic test_random();
    int len, pick;
    logic [6:0] dv;
    while (bins_sent < 1300) begin
      if ($urandom_range(0, 7) == 0) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: write_reg(sebd_pkg::CFG_MEAN_THR, $urandom_range(0, 4095));
          1: write_reg(sebd_pkg::CFG_MEAN_THR, $urandom_range(256, 400));
          2: write_reg(sebd_pkg::CFG_DEV_THR,
                       $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000));
          3: write_reg(sebd_pkg::CFG_DEV_THR, 32'd0);
          default: begin
            case ($urandom_range(0, 7))
              0: dv = 7'd127;
              1: dv = 7'd64;
              2: dv = 7'd0;
              default: dv = 7'($urandom_range(1, 8));
            endcase
            if (depth_safe(dv)) write_reg(sebd_pkg::CFG_DEPTH, 32'(dv));
          end
        endcase
      end
      pick = $urandom_range(0, 19);
      if (pick < 3) len = $urandom_range(FFT_LEN / 2 - 12, FFT_LEN / 2 + 8);
      else if (pick < 6) len = $urandom_range(FFT_LEN / 4 + 1, FFT_LEN / 2 - 13);
      else len = $urandom_range(1, 64);
      send_frame(len, $urandom_range(0, 3) == 0 ? 24 : $urandom_range(4, 20));
    end
  endtask

  task automatic test_backlog();
    send_frame(6, 16);
    wait_idle();
    send_frame(40, 12);
  endtask

  task automatic test_no_gaps();
    quiet = 1'b1;
    write_reg(sebd_pkg::CFG_DEPTH, 32'd4);
    for (int f = 0; f < 6; f++) send_frame($urandom_range(1, 40), 18);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (quiet) begin
      out_pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      out_pop <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      pop_hold <= $urandom_range(0, 17);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sebd_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pulse_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: pulse=%0b band=%0d",
                                       out_item.is_pulse, out_item.trigger_band);
      end else begin
        want = pulse_due.pop_front();
        if (out_item.is_pulse !== want.is_pulse ||
            out_item.trigger_band !== want.trigger_band) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame mismatch: expected pulse=%0b band=%0d, got pulse=%0b band=%0d",
                     want.is_pulse, want.trigger_band, out_item.is_pulse, out_item.trigger_band);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    mean_thr = 12'd333;
    dev_thr = '0;
    depth_reg = 7'd43;
    band_sum = '0;
    bin_pos = 0;
    ring_slot = 0;
    rows_filled = 0;
    for (int r = 0; r < ROWS_MAX; r++) begin
      row_written[r] = 1'b0;
      for (int b = 0; b < SLOTS; b++) history[r][b] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_registers();
    test_random();
    test_backlog();
    test_no_gaps();
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pulse_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sebd_pkg.sv
rtl/sebd_front.sv
rtl/sebd_fifo.sv
rtl/sebd_back.sv
rtl/subband_energy_beat_detector.sv
rtl/sebd_check.sv
verif/testbench.sv
